// File: hdl/mandelbulb_voxel_escape_test_defines.svh
// Assertion macros shared by the escape test RTL.
`ifndef MANDELBULB_VOXEL_ESCAPE_TEST_DEFINES_SVH
`define MANDELBULB_VOXEL_ESCAPE_TEST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBVET_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBVET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mbvet_pkg.sv
// Shared types, constants and the arctangent table of the escape test.
package mbvet_pkg;

  localparam int MAX_RESOLUTION = 512;
  localparam int MAX_ITERATIONS = 20;
  localparam int CORDIC_STAGES  = 24;
  localparam int STAGES_USED    = (CORDIC_STAGES > 30) ? 30 : CORDIC_STAGES;

  localparam int RES_W   = $clog2(MAX_RESOLUTION);
  localparam int LIM_W   = 5;
  localparam int DW      = 36;
  localparam int PW      = 2 * DW;
  localparam int HALF_W  = DW / 2;
  localparam int ZW      = 34;
  localparam int ANG_W   = 32;
  localparam int STG_W   = $clog2(STAGES_USED);
  localparam int NUM_W   = RES_W + 3 + 17;
  localparam int DVD_W   = NUM_W - 1 + 12;
  localparam int DVS_W   = RES_W + 1;
  localparam int NX_W    = 40;

  typedef logic signed [DW-1:0] dval_t;
  typedef logic signed [PW-1:0] prod_t;

  localparam dval_t INV_GAIN = 36'sd652032874;
  localparam prod_t RND24    = 72'sd8388608;
  localparam prod_t RND30    = 72'sd536870912;
  localparam prod_t Q24_MAX  = 72'sd2147483647;
  localparam logic signed [NX_W-1:0] NX_MAX = 40'sd2147483647;
  localparam logic signed [NX_W-1:0] NX_MIN = -40'sd2147483648;
  localparam logic [ANG_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic {CORD_VEC, CORD_ROT} cord_mode_t;

  typedef enum logic [2:0] {
    REG_RESOLUTION = 3'd0,
    REG_ITER_LIMIT = 3'd1,
    REG_POWER      = 3'd2,
    REG_EXTENT     = 3'd3,
    REG_ESC_RADIUS = 3'd4
  } cfg_reg_t;

  typedef enum logic [5:0] {
    S_IDLE, S_R2, S_R2_W, S_CO_MUL, S_CO_DIV, S_CO_W, S_IT,
    S_VEC1, S_VEC1_W, S_MAG1_W, S_VEC2, S_VEC2_W, S_MAG2_W,
    S_POW, S_POW_W, S_ROT1, S_ROT1_W, S_ROT2, S_ROT2_W,
    S_PX1, S_PX1_W, S_PX2, S_PX2_W, S_PY1, S_PY1_W, S_PY2, S_PY2_W,
    S_PZ, S_PZ_W, S_CHK, S_SQX, S_SQX_W, S_SQY, S_SQY_W, S_SQZ, S_SQZ_W,
    S_CMP, S_DONE
  } state_t;

  function automatic dval_t sx32(input logic signed [31:0] v);
    return {{(DW-32){v[31]}}, v};
  endfunction

  // Binary-angle arctangent of 2^-i.
  function automatic logic [ANG_W-1:0] atan_turn(input logic [STG_W-1:0] i);
    logic [ANG_W-1:0] t;
    case (i)
      5'd0:  t = 32'h2000_0000;
      5'd1:  t = 32'h12E4_051D;
      5'd2:  t = 32'h09FB_385B;
      5'd3:  t = 32'h0511_11D4;
      5'd4:  t = 32'h028B_0D43;
      5'd5:  t = 32'h0145_D7E1;
      5'd6:  t = 32'h00A2_F61E;
      5'd7:  t = 32'h0051_7C55;
      5'd8:  t = 32'h0028_BE53;
      5'd9:  t = 32'h0014_5F2E;
      5'd10: t = 32'h000A_2F98;
      5'd11: t = 32'h0005_17CC;
      5'd12: t = 32'h0002_8BE6;
      5'd13: t = 32'h0001_45F3;
      5'd14: t = 32'h0000_A2F9;
      5'd15: t = 32'h0000_517C;
      5'd16: t = 32'h0000_28BE;
      5'd17: t = 32'h0000_145F;
      5'd18: t = 32'h0000_0A2F;
      5'd19: t = 32'h0000_0517;
      5'd20: t = 32'h0000_028B;
      5'd21: t = 32'h0000_0145;
      5'd22: t = 32'h0000_00A2;
      5'd23: t = 32'h0000_0051;
      5'd24: t = 32'h0000_0028;
      5'd25: t = 32'h0000_0014;
      5'd26: t = 32'h0000_000A;
      5'd27: t = 32'h0000_0005;
      5'd28: t = 32'h0000_0002;
      5'd29: t = 32'h0000_0001;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: hdl/mbvet_mul.sv
// Shared signed multiplier, built from two partial products.
module mbvet_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mbvet_pkg::dval_t a,
  input  mbvet_pkg::dval_t b,
  output logic           busy,
  output logic           done,
  output mbvet_pkg::prod_t prod
);
  import mbvet_pkg::*;

  localparam int PART_W = DW + HALF_W + 1;

  dval_t a_r, b_r;
  prod_t acc_r, acc_nxt;
  logic  ph_r, busy_r, done_r;
  logic signed [HALF_W:0]   bsel;
  logic signed [PART_W-1:0] part;
  prod_t part_x;

  always_comb begin
    if (ph_r) begin
      bsel = {b_r[DW-1], b_r[DW-1:HALF_W]};
    end else begin
      bsel = {1'b0, b_r[HALF_W-1:0]};
    end
    part   = PART_W'(a_r) * PART_W'(bsel);
    part_x = {{(PW-PART_W){part[PART_W-1]}}, part};
    acc_nxt = ph_r ? (acc_r + (part_x <<< HALF_W)) : part_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        busy_r <= 1'b1;
        ph_r   <= 1'b0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        ph_r  <= ~ph_r;
        if (ph_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

// File: hdl/mbvet_div.sv
// Restoring divider for the voxel to coordinate mapping, one bit a cycle.
module mbvet_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [mbvet_pkg::DVD_W-1:0]   dividend,
  input  logic [mbvet_pkg::DVS_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [mbvet_pkg::DVD_W-1:0]   quot
);
  import mbvet_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r, d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_r, q_r[DVD_W-1]};
    ge    = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DVS_W'(trial - {1'b0, d_r}) : DVS_W'(trial);
        q_r   <= {q_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

// File: hdl/mbvet_cordic.sv
// Iterative CORDIC, one micro-rotation a cycle, in vectoring or rotation mode.
module mbvet_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  mbvet_pkg::cord_mode_t         mode,
  input  mbvet_pkg::dval_t              x_in,
  input  mbvet_pkg::dval_t              y_in,
  input  logic [mbvet_pkg::ANG_W-1:0]   ang_in,
  output logic                          busy,
  output logic                          done,
  output mbvet_pkg::dval_t              x_out,
  output mbvet_pkg::dval_t              y_out,
  output logic [mbvet_pkg::ANG_W-1:0]   ang_out
);
  import mbvet_pkg::*;

  cord_mode_t mode_r;
  dval_t x_r, y_r, x_n, y_n, xs, ys, x0, y0, xf, yf;
  logic signed [ZW-1:0] z_r, z_n, z0, at;
  logic [STG_W-1:0] stg_r;
  logic busy_r, done_r, zero_r, neg_r, zero0, neg0, s;
  logic [ANG_W-1:0] fold, a1;
  dval_t x_out_r, y_out_r;
  logic [ANG_W-1:0] ang_out_r;

  // Start values for both modes.
  always_comb begin
    zero0 = 1'b0;
    neg0  = 1'b0;
    fold  = ang_in + QUARTER_TURN;
    a1    = ang_in;
    if (mode == CORD_VEC) begin
      zero0 = (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x0 = -x_in;
        y0 = -y_in;
        z0 = {{(ZW-ANG_W){1'b0}}, HALF_TURN};
      end else begin
        x0 = x_in;
        y0 = y_in;
        z0 = '0;
      end
    end else begin
      // Angles in the left half-plane are turned by half a turn and the result negated.
      neg0 = fold[ANG_W-1];
      if (neg0) begin
        a1 = ang_in - HALF_TURN;
      end
      x0 = INV_GAIN;
      y0 = '0;
      z0 = {{(ZW-ANG_W){a1[ANG_W-1]}}, a1};
    end
  end

  always_comb begin
    s   = (mode_r == CORD_VEC) ? y_r[DW-1] : !z_r[ZW-1];
    xs  = x_r >>> stg_r;
    ys  = y_r >>> stg_r;
    at  = {{(ZW-ANG_W){1'b0}}, atan_turn(stg_r)};
    x_n = s ? (x_r - ys) : (x_r + ys);
    y_n = s ? (y_r + xs) : (y_r - xs);
    z_n = s ? (z_r - at) : (z_r + at);
    xf  = neg_r ? -x_n : x_n;
    yf  = neg_r ? -y_n : y_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      stg_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        mode_r <= mode;
        x_r    <= x0;
        y_r    <= y0;
        z_r    <= z0;
        zero_r <= zero0;
        neg_r  <= neg0;
        stg_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        x_r   <= x_n;
        y_r   <= y_n;
        z_r   <= z_n;
        stg_r <= stg_r + 1'b1;
        if (stg_r == STG_W'(STAGES_USED - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (mode_r == CORD_VEC) begin
            x_out_r   <= (zero_r || x_n < 0) ? '0 : x_n;
            y_out_r   <= y_n;
            ang_out_r <= zero_r ? '0 : z_n[ANG_W-1:0];
          end else begin
            x_out_r   <= (xf + 36'sd32) >>> 6;
            y_out_r   <= (yf + 36'sd32) >>> 6;
            ang_out_r <= z_n[ANG_W-1:0];
          end
        end
      end
    end
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign x_out   = x_out_r;
  assign y_out   = y_out_r;
  assign ang_out = ang_out_r;

endmodule

// File: hdl/mandelbulb_voxel_escape_test.sv
// Top level of the Mandelbulb voxel escape test: registers, sequencer and datapath.
//
// Usage: write the configuration registers over the APB port while the block is
// idle (resolution at 0x00, iteration_limit 0x04, power 0x08, extent 0x0C,
// escape_radius 0x10). Present a voxel index triple on in_x_index, in_y_index and
// in_z_index with start high; the item is taken at the edge where busy is low.
// busy then stays high until the result has been produced, and one item is
// worked on at a time.
// The result appears on out_inside_res for exactly one cycle with out_valid high
// and must be taken then, as the receiver cannot stall the block.
// The escape radius square and the three coordinate divisions are done first,
// then at most iteration_limit fractal iterations, capped at 20; a voxel that
// escapes early finishes early. The iterations share the single CORDIC (four
// calls per iteration) and the single multiplier used for radius powers and
// products; that multiplier also forms the escape radius square.
// Reset returns the registers to their defaults and the sequencer to idle;
// no result is pending after reset.
`include "mandelbulb_voxel_escape_test_defines.svh"

module mandelbulb_voxel_escape_test (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mbvet_pkg::RES_W-1:0]   in_x_index,
  input  logic [mbvet_pkg::RES_W-1:0]   in_y_index,
  input  logic [mbvet_pkg::RES_W-1:0]   in_z_index,
  output logic                          out_valid,
  output logic                          out_inside_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mbvet_pkg::*;

  // Configuration registers
  logic [RES_W-1:0] resolution_r;
  logic [LIM_W-1:0] iter_limit_r, power_r;
  logic [15:0]      extent_r, esc_radius_r;
  cfg_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= RES_W'(30);
      iter_limit_r <= LIM_W'(5);
      power_r      <= LIM_W'(8);
      extent_r     <= 16'd12288;
      esc_radius_r <= 16'd8192;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_RESOLUTION: resolution_r <= pwdata[RES_W-1:0];
        REG_ITER_LIMIT: iter_limit_r <= pwdata[LIM_W-1:0];
        REG_POWER:      power_r      <= pwdata[LIM_W-1:0];
        REG_EXTENT:     extent_r     <= pwdata[15:0];
        REG_ESC_RADIUS: esc_radius_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RESOLUTION: prdata = {{(32-RES_W){1'b0}}, resolution_r};
      REG_ITER_LIMIT: prdata = {{(32-LIM_W){1'b0}}, iter_limit_r};
      REG_POWER:      prdata = {{(32-LIM_W){1'b0}}, power_r};
      REG_EXTENT:     prdata = {16'd0, extent_r};
      REG_ESC_RADIUS: prdata = {16'd0, esc_radius_r};
      default:        prdata = '0;
    endcase
  end

  // Sequencer and datapath state
  state_t state_r, state_nxt;
  logic [RES_W-1:0] x_idx_r, y_idx_r, z_idx_r, idx_sel, res_eff;
  logic [1:0] axis_r;
  logic [LIM_W-1:0] limit_eff, it_r, k_r;
  logic signed [NUM_W-1:0] num_r;
  logic [NUM_W-2:0] num_abs;
  logic signed [11:0] diff;
  logic signed [31:0] cx_r, cy_r, cz_r, px_r, py_r, pz_r, c_new;
  logic [ANG_W-1:0] phi_r, theta_r;
  dval_t rxy_r, r_r, ct_r, st_r, cp_r, sp_r, t_r;
  logic signed [31:0] vr_r;
  logic signed [NX_W-1:0] nx_r, ny_r, nz_r;
  logic [63:0] sum_r;
  logic [55:0] r2_r;
  logic inside_r, out_valid_r, out_inside_r;
  prod_t rnd24, rnd30;
  logic c_ovf, n_fits;
  dval_t esc_q;

  // Shared units
  logic mul_start, mul_busy, mul_done;
  dval_t mul_a, mul_b;
  prod_t mul_prod;
  logic cord_start, cord_busy, cord_done;
  cord_mode_t cord_mode;
  dval_t cord_x, cord_y, cord_xo, cord_yo;
  logic [ANG_W-1:0] cord_ang, cord_ango;
  logic div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_quot;

  mbvet_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .prod(mul_prod)
  );

  mbvet_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cord_start), .mode(cord_mode),
    .x_in(cord_x), .y_in(cord_y), .ang_in(cord_ang),
    .busy(cord_busy), .done(cord_done), .x_out(cord_xo), .y_out(cord_yo),
    .ang_out(cord_ango)
  );

  mbvet_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor({res_eff, 1'b0}), .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_inside_res = out_inside_r;

  always_comb begin
    res_eff   = (resolution_r == '0) ? RES_W'(1) : resolution_r;
    limit_eff = (iter_limit_r > LIM_W'(MAX_ITERATIONS)) ? LIM_W'(MAX_ITERATIONS)
                                                        : iter_limit_r;
    case (axis_r)
      2'd0:    idx_sel = x_idx_r;
      2'd1:    idx_sel = y_idx_r;
      default: idx_sel = z_idx_r;
    endcase
    diff    = $signed({2'b00, idx_sel, 1'b0}) - $signed({3'b000, res_eff});
    num_abs = num_r[NUM_W-1] ? (NUM_W-1)'(-num_r) : num_r[NUM_W-2:0];
    div_dvd = {num_abs, 12'd0} + {{(DVD_W-RES_W){1'b0}}, res_eff};
    c_ovf   = |div_quot[DVD_W-1:31];
    c_new   = num_r[NUM_W-1] ? -$signed(div_quot[31:0]) : $signed(div_quot[31:0]);
    rnd24   = (mul_prod + RND24) >>> 24;
    rnd30   = (mul_prod + RND30) >>> 30;
    n_fits  = (nx_r <= NX_MAX) && (nx_r >= NX_MIN) && (ny_r <= NX_MAX) &&
              (ny_r >= NX_MIN) && (nz_r <= NX_MAX) && (nz_r >= NX_MIN);
    esc_q   = {{(DW-28){1'b0}}, esc_radius_r, 12'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    cord_start = 1'b0;
    cord_mode  = CORD_VEC;
    cord_x     = '0;
    cord_y     = '0;
    cord_ang   = '0;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_R2;
      S_R2: begin
        mul_start = 1'b1;
        mul_a     = esc_q;
        mul_b     = esc_q;
        state_nxt = S_R2_W;
      end
      S_R2_W: if (mul_done) state_nxt = S_CO_MUL;
      S_CO_MUL: state_nxt = S_CO_DIV;
      S_CO_DIV: begin
        div_start = 1'b1;
        state_nxt = S_CO_W;
      end
      S_CO_W: begin
        if (div_done) begin
          if (c_ovf) state_nxt = S_DONE;
          else if (axis_r == 2'd2) state_nxt = S_IT;
          else state_nxt = S_CO_MUL;
        end
      end
      S_IT: state_nxt = (it_r == limit_eff) ? S_DONE : S_VEC1;
      S_VEC1: begin
        cord_start = 1'b1;
        cord_x     = sx32(px_r);
        cord_y     = sx32(py_r);
        state_nxt  = S_VEC1_W;
      end
      S_VEC1_W: begin
        if (cord_done) begin
          mul_start = 1'b1;
          mul_a     = cord_xo;
          mul_b     = INV_GAIN;
          state_nxt = S_MAG1_W;
        end
      end
      S_MAG1_W: if (mul_done) state_nxt = S_VEC2;
      S_VEC2: begin
        cord_start = 1'b1;
        cord_x     = sx32(pz_r);
        cord_y     = rxy_r;
        state_nxt  = S_VEC2_W;
      end
      S_VEC2_W: begin
        if (cord_done) begin
          mul_start = 1'b1;
          mul_a     = cord_xo;
          mul_b     = INV_GAIN;
          state_nxt = S_MAG2_W;
        end
      end
      S_MAG2_W: if (mul_done) state_nxt = S_POW;
      S_POW: begin
        if (k_r == power_r) begin
          state_nxt = S_ROT1;
        end else begin
          mul_start = 1'b1;
          mul_a     = sx32(vr_r);
          mul_b     = r_r;
          state_nxt = S_POW_W;
        end
      end
      S_POW_W: if (mul_done) state_nxt = (rnd24 > Q24_MAX) ? S_DONE : S_POW;
      S_ROT1: begin
        cord_start = 1'b1;
        cord_mode  = CORD_ROT;
        cord_ang   = theta_r * {{(ANG_W-LIM_W){1'b0}}, power_r};
        state_nxt  = S_ROT1_W;
      end
      S_ROT1_W: if (cord_done) state_nxt = S_ROT2;
      S_ROT2: begin
        cord_start = 1'b1;
        cord_mode  = CORD_ROT;
        cord_ang   = phi_r * {{(ANG_W-LIM_W){1'b0}}, power_r};
        state_nxt  = S_ROT2_W;
      end
      S_ROT2_W: if (cord_done) state_nxt = S_PX1;
      S_PX1: begin
        mul_start = 1'b1;
        mul_a     = st_r;
        mul_b     = cp_r;
        state_nxt = S_PX1_W;
      end
      S_PX1_W: if (mul_done) state_nxt = S_PX2;
      S_PX2: begin
        mul_start = 1'b1;
        mul_a     = t_r;
        mul_b     = sx32(vr_r);
        state_nxt = S_PX2_W;
      end
      S_PX2_W: if (mul_done) state_nxt = S_PY1;
      S_PY1: begin
        mul_start = 1'b1;
        mul_a     = st_r;
        mul_b     = sp_r;
        state_nxt = S_PY1_W;
      end
      S_PY1_W: if (mul_done) state_nxt = S_PY2;
      S_PY2: begin
        mul_start = 1'b1;
        mul_a     = t_r;
        mul_b     = sx32(vr_r);
        state_nxt = S_PY2_W;
      end
      S_PY2_W: if (mul_done) state_nxt = S_PZ;
      S_PZ: begin
        mul_start = 1'b1;
        mul_a     = ct_r;
        mul_b     = sx32(vr_r);
        state_nxt = S_PZ_W;
      end
      S_PZ_W: if (mul_done) state_nxt = S_CHK;
      S_CHK: state_nxt = n_fits ? S_SQX : S_DONE;
      S_SQX: begin
        mul_start = 1'b1;
        mul_a     = sx32(nx_r[31:0]);
        mul_b     = sx32(nx_r[31:0]);
        state_nxt = S_SQX_W;
      end
      S_SQX_W: if (mul_done) state_nxt = S_SQY;
      S_SQY: begin
        mul_start = 1'b1;
        mul_a     = sx32(ny_r[31:0]);
        mul_b     = sx32(ny_r[31:0]);
        state_nxt = S_SQY_W;
      end
      S_SQY_W: if (mul_done) state_nxt = S_SQZ;
      S_SQZ: begin
        mul_start = 1'b1;
        mul_a     = sx32(nz_r[31:0]);
        mul_b     = sx32(nz_r[31:0]);
        state_nxt = S_SQZ_W;
      end
      S_SQZ_W: if (mul_done) state_nxt = S_CMP;
      S_CMP: state_nxt = (sum_r > {8'd0, r2_r}) ? S_DONE : S_IT;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          x_idx_r  <= in_x_index;
          y_idx_r  <= in_y_index;
          z_idx_r  <= in_z_index;
          axis_r   <= 2'd0;
          it_r     <= '0;
          inside_r <= 1'b1;
        end
      end
      S_R2_W: if (mul_done) r2_r <= mul_prod[55:0];
      S_CO_MUL: num_r <= NUM_W'(diff) * NUM_W'($signed({1'b0, extent_r}));
      S_CO_W: begin
        if (div_done) begin
          if (c_ovf) begin
            inside_r <= 1'b0;
          end else begin
            case (axis_r)
              2'd0: begin
                cx_r <= c_new;
                px_r <= c_new;
              end
              2'd1: begin
                cy_r <= c_new;
                py_r <= c_new;
              end
              default: begin
                cz_r <= c_new;
                pz_r <= c_new;
              end
            endcase
          end
          axis_r <= axis_r + 2'd1;
        end
      end
      S_VEC1_W: if (cord_done) phi_r <= cord_ango;
      S_MAG1_W: if (mul_done) rxy_r <= rnd30[DW-1:0];
      S_VEC2_W: if (cord_done) theta_r <= cord_ango;
      S_MAG2_W: begin
        if (mul_done) begin
          r_r  <= rnd30[DW-1:0];
          vr_r <= 32'sd16777216;
          k_r  <= '0;
        end
      end
      S_POW_W: begin
        if (mul_done) begin
          if (rnd24 > Q24_MAX) begin
            inside_r <= 1'b0;
          end else begin
            vr_r <= rnd24[31:0];
            k_r  <= k_r + 1'b1;
          end
        end
      end
      S_ROT1_W: begin
        if (cord_done) begin
          ct_r <= cord_xo;
          st_r <= cord_yo;
        end
      end
      S_ROT2_W: begin
        if (cord_done) begin
          cp_r <= cord_xo;
          sp_r <= cord_yo;
        end
      end
      S_PX1_W, S_PY1_W: if (mul_done) t_r <= rnd24[DW-1:0];
      S_PX2_W: if (mul_done) nx_r <= rnd24[NX_W-1:0] + {{(NX_W-32){cx_r[31]}}, cx_r};
      S_PY2_W: if (mul_done) ny_r <= rnd24[NX_W-1:0] + {{(NX_W-32){cy_r[31]}}, cy_r};
      S_PZ_W:  if (mul_done) nz_r <= rnd24[NX_W-1:0] + {{(NX_W-32){cz_r[31]}}, cz_r};
      S_CHK: if (!n_fits) inside_r <= 1'b0;
      S_SQX_W: if (mul_done) sum_r <= mul_prod[63:0];
      S_SQY_W, S_SQZ_W: if (mul_done) sum_r <= sum_r + mul_prod[63:0];
      S_CMP: begin
        if (sum_r > {8'd0, r2_r}) begin
          inside_r <= 1'b0;
        end else begin
          px_r <= nx_r[31:0];
          py_r <= ny_r[31:0];
          pz_r <= nz_r[31:0];
          it_r <= it_r + 1'b1;
        end
      end
      S_DONE: out_inside_r <= inside_r;
      default: ;
    endcase
  end

  `MBVET_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
  `MBVET_ASSERT_SAME(a_out_idle, out_valid, !busy, "result shown while still busy")
  `MBVET_ASSERT_SAME(a_mul_free, mul_start, !cord_busy && !div_busy, "multiplier overlaps")
  `MBVET_ASSERT_SAME(a_cord_free, cord_start, !mul_busy && !div_busy, "CORDIC overlaps")

endmodule
